[rtl/core/smdp_pkg.sv]
// Shared types, codes and constant tables of the sensor message deframer and parser.
package smdp_pkg;

  // Sizes and register map.
  localparam int NUM_SENSORS = 6;
  localparam int KEY_MAX_LEN = 10;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_MESSAGE_LENGTH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_TERMINATOR_RUN     = 1'b1;

  localparam logic [7:0] MAX_LEN_RESET  = 8'd100;
  localparam logic [2:0] TERM_RUN_RESET = 3'd3;

  // Byte codes that the deframer looks for.
  localparam logic [7:0] BYTE_TERM  = 8'hFF;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_TILDE = 8'h7E;
  localparam logic [7:0] BYTE_PLUS  = 8'h2B;
  localparam logic [7:0] BYTE_MINUS = 8'h2D;
  localparam logic [7:0] BYTE_ZERO  = 8'h30;
  localparam logic [7:0] BYTE_NINE  = 8'h39;

  localparam logic [15:0] MAG_MAX = 16'hFFFF;

  // Sensor identifiers.
  localparam logic [2:0] SID_CO2  = 3'd0;
  localparam logic [2:0] SID_PM25 = 3'd1;
  localparam logic [2:0] SID_O3   = 3'd2;
  localparam logic [2:0] SID_TEMP = 3'd3;
  localparam logic [2:0] SID_HUM  = 3'd4;
  localparam logic [2:0] SID_TVOC = 3'd5;

  // Key prefixes, first character first, padded with zero bytes.
  localparam logic [7:0] KEY_TEXT [NUM_SENSORS][KEY_MAX_LEN] = '{
    '{"c", "o", "2", "V", ".", "v", "a", "l", "=", 8'h00},
    '{"p", "m", "2", "5", "V", ".", "v", "a", "l", "="},
    '{"o", "3", "V", ".", "v", "a", "l", "=", 8'h00, 8'h00},
    '{"t", "e", "m", "p", "V", ".", "v", "a", "l", "="},
    '{"h", "u", "m", "V", ".", "v", "a", "l", "=", 8'h00},
    '{"t", "v", "o", "c", "V", ".", "v", "a", "l", "="}
  };
  localparam logic [3:0] KEY_LEN [NUM_SENSORS] = '{4'd9, 4'd10, 4'd8, 4'd10, 4'd9, 4'd10};

  // Accepted value ranges, inclusive.
  localparam logic signed [16:0] RANGE_LO [NUM_SENSORS] = '{
    17'sd1, 17'sd0, 17'sd0, -17'sd50, 17'sd0, 17'sd0
  };
  localparam logic signed [16:0] RANGE_HI [NUM_SENSORS] = '{
    17'sd9999, 17'sd1999, 17'sd1999, 17'sd99, 17'sd100, 17'sd1999
  };

  typedef enum logic [1:0] {
    PH_PREFIX,
    PH_LEAD,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_EVAL,
    CMD_UNKNOWN,
    CMD_OVERFLOW
  } cmd_kind_t;

  typedef enum logic [2:0] {
    ST_NOTHING      = 3'd0,
    ST_STORED       = 3'd1,
    ST_OUT_OF_RANGE = 3'd2,
    ST_UNKNOWN_KEY  = 3'd3,
    ST_OVERFLOW     = 3'd4
  } status_t;

  // Configuration write request.
  typedef struct packed {
    logic                   we;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_write_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    cmd_kind_t          kind;
    logic [2:0]         sid;
    logic signed [16:0] value;
  } cmd_t;

  // One result as it waits in the output queue.
  typedef struct packed {
    status_t            status;
    logic [2:0]         sid;
    logic signed [16:0] value;
    logic [13:0]        co2;
    logic [10:0]        pm25;
    logic [10:0]        ozone;
    logic signed [7:0]  temp;
    logic [6:0]         hum;
    logic [10:0]        voc;
  } res_t;

endpackage

[rtl/core/smdp_fifo.sv]
// Small first-in first-out queue held in flip-flops.
module smdp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

[rtl/core/smdp_front.sv]
// Front part: deframes received bytes, matches key prefixes and accumulates the value.
module smdp_front (
  input  logic                clk,
  input  logic                rst,
  input  smdp_pkg::cfg_write_t cfg,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  output smdp_pkg::cmd_t      cmd
);

  logic [7:0]       max_len;
  logic [2:0]       term_run;
  logic [2:0]       ff_run;
  logic [2:0]       ff_run_next;
  logic [7:0]       msg_length;
  logic [8:0]       len_next;
  logic [5:0]       key_candidates;
  logic [5:0]       cand_next;
  smdp_pkg::phase_t parse_phase;
  smdp_pkg::phase_t phase_next;
  logic             negative_sign;
  logic             neg_next;
  logic [15:0]      magnitude;
  logic [15:0]      mag_next;

  logic             is_ff;
  logic             is_print;
  logic             is_digit;
  logic             term;
  logic [2:0]       ff_inc;
  logic [8:0]       len_inc;
  logic [3:0]       char_idx;
  logic [5:0]       cand_kept;
  logic [5:0]       cand_final;
  logic             key_done;
  logic [2:0]       first_sid;
  logic [19:0]      mag_times;
  logic [15:0]      mag_sat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len  <= smdp_pkg::MAX_LEN_RESET;
      term_run <= smdp_pkg::TERM_RUN_RESET;
    end else if (cfg.we) begin
      unique case (cfg.index)
        smdp_pkg::REG_MAX_MESSAGE_LENGTH: max_len  <= cfg.data;
        smdp_pkg::REG_TERMINATOR_RUN:     term_run <= cfg.data[2:0];
      endcase
    end
  end

  // Byte classes and the terminator run.
  assign is_ff    = (rx_byte == smdp_pkg::BYTE_TERM);
  assign is_print = (rx_byte >= smdp_pkg::BYTE_SPACE) && (rx_byte <= smdp_pkg::BYTE_TILDE);
  assign is_digit = (rx_byte >= smdp_pkg::BYTE_ZERO) && (rx_byte <= smdp_pkg::BYTE_NINE);
  assign ff_inc   = ff_run + 3'd1;
  assign term     = is_ff && (ff_inc >= term_run);
  assign len_inc  = {1'b0, msg_length} + 9'd1;
  assign char_idx = (msg_length < 8'(smdp_pkg::KEY_MAX_LEN)) ? msg_length[3:0] : '0;

  // Prefix matching: drop keys that disagree, then lock on a completed key.
  always_comb begin
    cand_kept = key_candidates;
    for (int k = 0; k < smdp_pkg::NUM_SENSORS; k++) begin
      if ((msg_length < {4'b0, smdp_pkg::KEY_LEN[k]}) &&
          (smdp_pkg::KEY_TEXT[k][char_idx] != rx_byte)) begin
        cand_kept[k] = 1'b0;
      end
    end
    cand_final = cand_kept;
    key_done   = 1'b0;
    for (int k = 0; k < smdp_pkg::NUM_SENSORS; k++) begin
      if (cand_kept[k] && ({5'b0, smdp_pkg::KEY_LEN[k]} == len_inc)) begin
        cand_final    = '0;
        cand_final[k] = 1'b1;
        key_done      = 1'b1;
      end
    end
  end

  // Lowest remaining candidate names the sensor.
  always_comb begin
    first_sid = '0;
    for (int k = smdp_pkg::NUM_SENSORS - 1; k >= 0; k--) begin
      if (key_candidates[k]) begin
        first_sid = 3'(k);
      end
    end
  end

  // Decimal accumulate with saturation.
  assign mag_times = ({4'b0, magnitude} << 3) + ({4'b0, magnitude} << 1) +
                     {16'b0, rx_byte[3:0]};
  assign mag_sat   = (mag_times > {4'b0, smdp_pkg::MAG_MAX}) ? smdp_pkg::MAG_MAX
                                                              : mag_times[15:0];

  // Next state and the classified request for this byte.
  always_comb begin
    ff_run_next = ff_run;
    len_next    = {1'b0, msg_length};
    cand_next   = key_candidates;
    phase_next  = parse_phase;
    neg_next    = negative_sign;
    mag_next    = magnitude;
    cmd.kind    = smdp_pkg::CMD_NONE;
    cmd.sid     = '0;
    cmd.value   = '0;

    if (is_ff) begin
      ff_run_next = ff_inc;
      if (term) begin
        ff_run_next = '0;
        if (msg_length != '0) begin
          if (parse_phase == smdp_pkg::PH_PREFIX || key_candidates == '0) begin
            cmd.kind = smdp_pkg::CMD_UNKNOWN;
          end else begin
            cmd.kind  = smdp_pkg::CMD_EVAL;
            cmd.sid   = first_sid;
            cmd.value = negative_sign ? -$signed({1'b0, magnitude}) : $signed({1'b0, magnitude});
          end
          len_next   = '0;
          cand_next  = '1;
          phase_next = smdp_pkg::PH_PREFIX;
          neg_next   = 1'b0;
          mag_next   = '0;
        end
      end
    end else begin
      ff_run_next = '0;
      if (is_print) begin
        len_next = len_inc;
        unique case (parse_phase)
          smdp_pkg::PH_PREFIX: begin
            cand_next = cand_final;
            if (key_done) begin
              phase_next = smdp_pkg::PH_LEAD;
            end
          end
          smdp_pkg::PH_LEAD: begin
            priority if (rx_byte == smdp_pkg::BYTE_SPACE) begin
              phase_next = smdp_pkg::PH_LEAD;
            end else if (rx_byte == smdp_pkg::BYTE_PLUS || rx_byte == smdp_pkg::BYTE_MINUS) begin
              neg_next   = (rx_byte == smdp_pkg::BYTE_MINUS);
              phase_next = smdp_pkg::PH_DIGITS;
            end else if (is_digit) begin
              mag_next   = mag_sat;
              phase_next = smdp_pkg::PH_DIGITS;
            end else begin
              phase_next = smdp_pkg::PH_DONE;
            end
          end
          smdp_pkg::PH_DIGITS: begin
            if (is_digit) begin
              mag_next = mag_sat;
            end else begin
              phase_next = smdp_pkg::PH_DONE;
            end
          end
          smdp_pkg::PH_DONE: begin
            phase_next = smdp_pkg::PH_DONE;
          end
        endcase
      end
    end

    // Too long a message is thrown away; a termination has already cleared it.
    if (len_next > {1'b0, max_len}) begin
      len_next    = '0;
      cand_next   = '1;
      phase_next  = smdp_pkg::PH_PREFIX;
      neg_next    = 1'b0;
      mag_next    = '0;
      ff_run_next = '0;
      cmd.kind    = smdp_pkg::CMD_OVERFLOW;
      cmd.sid     = '0;
      cmd.value   = '0;
    end
  end

  // Message state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ff_run         <= '0;
      msg_length     <= '0;
      key_candidates <= '1;
      parse_phase    <= smdp_pkg::PH_PREFIX;
      negative_sign  <= 1'b0;
      magnitude      <= '0;
    end else if (accept) begin
      ff_run         <= ff_run_next;
      msg_length     <= len_next[7:0];
      key_candidates <= cand_next;
      parse_phase    <= phase_next;
      negative_sign  <= neg_next;
      magnitude      <= mag_next;
    end
  end

  // Once a key is complete exactly one candidate remains.
  a_locked_key: assert property (@(posedge clk) disable iff (rst)
    parse_phase != smdp_pkg::PH_PREFIX |-> $onehot(key_candidates))
    else $error("more than one key candidate after the prefix");

  // A terminating run leaves an empty message and a cleared run.
  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    accept && term |=> ff_run == '0 && msg_length == '0)
    else $error("terminator run did not clear the message");

  // A stored message never exceeds the length limit.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    accept && !cfg.we |=> msg_length <= max_len)
    else $error("message length above the limit");

endmodule

[rtl/core/smdp_back.sv]
// Back part: range checks parsed values, updates the sensor levels and builds results.
module smdp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  smdp_pkg::cmd_t cmd,
  output smdp_pkg::res_t res
);

  logic [13:0]        co2;
  logic [10:0]        pm25;
  logic [10:0]        ozone;
  logic signed [7:0]  temp;
  logic [6:0]         hum;
  logic [10:0]        voc;
  logic [2:0]         sid_idx;
  logic               in_range;
  logic               store;

  // Range check against the selected sensor's limits.
  assign sid_idx  = (cmd.sid < 3'(smdp_pkg::NUM_SENSORS)) ? cmd.sid : '0;
  assign in_range = (cmd.value >= smdp_pkg::RANGE_LO[sid_idx]) &&
                    (cmd.value <= smdp_pkg::RANGE_HI[sid_idx]);
  assign store    = (cmd.kind == smdp_pkg::CMD_EVAL) && in_range;

  // Result fields and the levels as they stand after this request.
  always_comb begin
    res.status = smdp_pkg::ST_NOTHING;
    res.sid    = '0;
    res.value  = '0;
    unique case (cmd.kind)
      smdp_pkg::CMD_NONE:     res.status = smdp_pkg::ST_NOTHING;
      smdp_pkg::CMD_EVAL: begin
        res.status = in_range ? smdp_pkg::ST_STORED : smdp_pkg::ST_OUT_OF_RANGE;
        res.sid    = cmd.sid;
        res.value  = cmd.value;
      end
      smdp_pkg::CMD_UNKNOWN:  res.status = smdp_pkg::ST_UNKNOWN_KEY;
      smdp_pkg::CMD_OVERFLOW: res.status = smdp_pkg::ST_OVERFLOW;
    endcase
    res.co2   = (store && cmd.sid == smdp_pkg::SID_CO2)  ? cmd.value[13:0] : co2;
    res.pm25  = (store && cmd.sid == smdp_pkg::SID_PM25) ? cmd.value[10:0] : pm25;
    res.ozone = (store && cmd.sid == smdp_pkg::SID_O3)   ? cmd.value[10:0] : ozone;
    res.temp  = (store && cmd.sid == smdp_pkg::SID_TEMP) ? cmd.value[7:0]  : temp;
    res.hum   = (store && cmd.sid == smdp_pkg::SID_HUM)  ? cmd.value[6:0]  : hum;
    res.voc   = (store && cmd.sid == smdp_pkg::SID_TVOC) ? cmd.value[10:0] : voc;
  end

  // Sensor level registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      co2   <= '0;
      pm25  <= '0;
      ozone <= '0;
      temp  <= '0;
      hum   <= '0;
      voc   <= '0;
    end else if (fire) begin
      co2   <= res.co2;
      pm25  <= res.pm25;
      ozone <= res.ozone;
      temp  <= res.temp;
      hum   <= res.hum;
      voc   <= res.voc;
    end
  end

endmodule

[rtl/core/sensor_message_deframer_parser_unit.sv]
// Top level of the sensor message deframer and parser.
//
// Input channel: one received serial byte per request on rx_byte, taken at a
// clock edge with push high and full low. Output channel: one result per byte,
// shown while empty is low and taken at an edge with pop high. A result holds
// a status code, the sensor and parsed value of a finished message, and the
// six stored sensor levels as they stand after that byte.
// Configuration: cfg_we writes cfg_data into the register cfg_index names
// (0 maximum message length, 1 terminator run length). The user must write
// only while idle; the block does not enforce it. A byte accepted by the
// front is classified into the request queue; the back range checks the
// oldest request, one per cycle while the output queue has room, and
// writes its result there; results reach the output ports in order.
// Throughput: one byte per cycle while full stays low, from the
// combinational prefix compare and decimal accumulate in the front.
// Reset clears the message state, restores the register defaults and zeroes
// the sensor levels; both queues come up empty. When the receiver stalls the
// output queue fills, then the request queue, and full rises after
// CMD_DEPTH + RES_DEPTH bytes are waiting.
module sensor_message_deframer_parser_unit #(
  parameter int CMD_DEPTH = 4,
  parameter int RES_DEPTH = 2
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic [7:0]                           rx_byte,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [2:0]                           status,
  output logic [2:0]                           sensor_id,
  output logic signed [16:0]                   parsed_value,
  output logic [13:0]                          co2_level,
  output logic [10:0]                          pm25_level,
  output logic [10:0]                          ozone_level,
  output logic signed [7:0]                    temperature,
  output logic [6:0]                           humidity,
  output logic [10:0]                          voc_level,
  input  logic                                 cfg_we,
  input  logic [smdp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [smdp_pkg::CFG_DATA_W-1:0]      cfg_data
);

  smdp_pkg::cfg_write_t cfg;
  smdp_pkg::cmd_t       cmd_in;
  smdp_pkg::cmd_t       cmd_out;
  smdp_pkg::res_t       res_in;
  smdp_pkg::res_t       res_out;
  logic                 accept;
  logic                 cmd_empty;
  logic                 res_full;
  logic                 back_fire;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // Input handshake.
  assign accept = push && !full;

  // Front: deframing and parsing.
  smdp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .rx_byte (rx_byte),
    .cmd     (cmd_in)
  );

  // Request queue between front and back.
  smdp_fifo #(
    .WIDTH ($bits(smdp_pkg::cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (cmd_in),
    .full      (full),
    .pop       (back_fire),
    .pop_data  (cmd_out),
    .empty     (cmd_empty)
  );

  // Back: range check and level store, one request per cycle while the output queue has room.
  assign back_fire = !cmd_empty && !res_full;

  smdp_back u_back (
    .clk  (clk),
    .rst  (rst),
    .fire (back_fire),
    .cmd  (cmd_out),
    .res  (res_in)
  );

  // Output queue.
  smdp_fifo #(
    .WIDTH ($bits(smdp_pkg::res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (back_fire),
    .push_data (res_in),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (res_out),
    .empty     (empty)
  );

  // Result ports.
  assign status       = res_out.status;
  assign sensor_id    = res_out.sid;
  assign parsed_value = res_out.value;
  assign co2_level    = res_out.co2;
  assign pm25_level   = res_out.pm25;
  assign ozone_level  = res_out.ozone;
  assign temperature  = res_out.temp;
  assign humidity     = res_out.hum;
  assign voc_level    = res_out.voc;

endmodule

[sim/testbench.sv]
// Self-checking testbench for the sensor message deframer and parser.
module testbench;

  // Clock, reset and block ports.
  logic clk = 1'b0;
  logic rst;
  logic push;
  logic full;
  logic [7:0] rx_byte;
  logic empty;
  logic pop = 1'b0;
  logic [2:0] status;
  logic [2:0] sensor_id;
  logic signed [16:0] parsed_value;
  logic [13:0] co2_level;
  logic [10:0] pm25_level;
  logic [10:0] ozone_level;
  logic signed [7:0] temperature;
  logic [6:0] humidity;
  logic [10:0] voc_level;
  logic cfg_we;
  logic [smdp_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [smdp_pkg::CFG_DATA_W-1:0] cfg_data;

  // Handshake and output values as they stand just before each rising edge.
  logic full_seen;
  logic empty_seen;
  smdp_pkg::res_t seen_result;
  smdp_pkg::res_t oldest_report;

  // Expected reports, one per accepted byte, oldest first.
  smdp_pkg::res_t pending_reports[$];
  int mismatches = 0;
  int bytes_sent = 0;
  int idle_pct = 36;

  // Deframer copy: registers, message state and stored levels.
  logic [7:0] max_len_reg;
  logic [2:0] term_run_reg;
  logic [2:0] ff_count;
  int msg_len;
  logic [5:0] key_hits;
  smdp_pkg::phase_t phase;
  logic neg;
  int mag;
  logic [15:0] level_store [smdp_pkg::NUM_SENSORS];

  string sensor_key [smdp_pkg::NUM_SENSORS] = '{
    "co2V.val=", "pm25V.val=", "o3V.val=", "tempV.val=", "humV.val=", "tvocV.val="
  };
  int range_min [smdp_pkg::NUM_SENSORS] = '{1, 0, 0, -50, 0, 0};
  int range_max [smdp_pkg::NUM_SENSORS] = '{9999, 1999, 1999, 99, 100, 1999};

  sensor_message_deframer_parser_unit DUT (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .rx_byte(rx_byte),
    .empty(empty),
    .pop(pop),
    .status(status),
    .sensor_id(sensor_id),
    .parsed_value(parsed_value),
    .co2_level(co2_level),
    .pm25_level(pm25_level),
    .ozone_level(ozone_level),
    .temperature(temperature),
    .humidity(humidity),
    .voc_level(voc_level),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Free-running clock, period 20.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sample the outputs on the falling edge, away from the rising edge that changes them.
  always @(negedge clk) begin
    full_seen = full;
    empty_seen = empty;
    seen_result = smdp_pkg::res_t'({status, sensor_id, parsed_value, co2_level, pm25_level,
                                    ozone_level, temperature, humidity, voc_level});
  end

  // Receiver side: pop at random unless idling is switched off.
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= idle_pct);
  end

  // Compare one field of a result and count a mismatch.
  function automatic void check_field(input string name, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Each accepted result is compared with the oldest expected report.
  always @(posedge clk) begin
    if (!rst && pop && !empty_seen) begin
      if (pending_reports.size() == 0) begin
        $error("result arrived with no request outstanding");
        mismatches++;
      end else begin
        oldest_report = pending_reports.pop_front();
        check_field("status", oldest_report.status, seen_result.status);
        check_field("sensor_id", oldest_report.sid, seen_result.sid);
        check_field("parsed_value", oldest_report.value, seen_result.value);
        check_field("co2_level", oldest_report.co2, seen_result.co2);
        check_field("pm25_level", oldest_report.pm25, seen_result.pm25);
        check_field("ozone_level", oldest_report.ozone, seen_result.ozone);
        check_field("temperature", oldest_report.temp, seen_result.temp);
        check_field("humidity", oldest_report.hum, seen_result.hum);
        check_field("voc_level", oldest_report.voc, seen_result.voc);
      end
    end
  end

  // Start a new message: no key decided yet and no number seen.
  function automatic void clear_message();
    msg_len = 0;
    key_hits = '1;
    phase = smdp_pkg::PH_PREFIX;
    neg = 1'b0;
    mag = 0;
  endfunction

  // Advance the deframer by one byte and return the report it produces.
  function automatic smdp_pkg::res_t deframe_byte(input logic [7:0] b);
    smdp_pkg::res_t r;
    smdp_pkg::status_t st;
    int k;
    int p;
    int sid;
    int val;
    int digit;
    st = smdp_pkg::ST_NOTHING;
    sid = 0;
    val = 0;
    if (b == smdp_pkg::BYTE_TERM) begin
      ff_count = ff_count + 3'd1;
      if (ff_count >= term_run_reg) begin
        // A completed run evaluates a non-empty message.
        if (msg_len > 0) begin
          if (phase == smdp_pkg::PH_PREFIX || key_hits == '0) begin
            st = smdp_pkg::ST_UNKNOWN_KEY;
          end else begin
            for (k = smdp_pkg::NUM_SENSORS - 1; k >= 0; k--) begin
              if (key_hits[k]) sid = k;
            end
            val = neg ? -mag : mag;
            if (val >= range_min[sid] && val <= range_max[sid]) begin
              level_store[sid] = val[15:0];
              st = smdp_pkg::ST_STORED;
            end else begin
              st = smdp_pkg::ST_OUT_OF_RANGE;
            end
          end
          clear_message();
        end
        ff_count = '0;
      end
    end else begin
      ff_count = '0;
      if (b >= smdp_pkg::BYTE_SPACE && b <= smdp_pkg::BYTE_TILDE) begin
        p = msg_len;
        if (phase == smdp_pkg::PH_PREFIX) begin
          // Drop keys that disagree at this position; a finished key wins.
          for (k = 0; k < smdp_pkg::NUM_SENSORS; k++) begin
            if (p < sensor_key[k].len() && sensor_key[k][p] != b) key_hits[k] = 1'b0;
          end
          for (k = 0; k < smdp_pkg::NUM_SENSORS; k++) begin
            if (key_hits[k] && sensor_key[k].len() == p + 1) begin
              key_hits = 6'b1 << k;
              phase = smdp_pkg::PH_LEAD;
            end
          end
        end else if (phase == smdp_pkg::PH_LEAD && b == smdp_pkg::BYTE_SPACE) begin
          // Leading spaces before the number are skipped.
        end else if (phase == smdp_pkg::PH_LEAD &&
                     (b == smdp_pkg::BYTE_PLUS || b == smdp_pkg::BYTE_MINUS)) begin
          neg = (b == smdp_pkg::BYTE_MINUS);
          phase = smdp_pkg::PH_DIGITS;
        end else if ((phase == smdp_pkg::PH_LEAD || phase == smdp_pkg::PH_DIGITS) &&
                     b >= smdp_pkg::BYTE_ZERO && b <= smdp_pkg::BYTE_NINE) begin
          digit = int'(b) - int'(smdp_pkg::BYTE_ZERO);
          mag = mag * 10 + digit;
          if (mag > int'(smdp_pkg::MAG_MAX)) mag = int'(smdp_pkg::MAG_MAX);
          phase = smdp_pkg::PH_DIGITS;
        end else begin
          phase = smdp_pkg::PH_DONE;
        end
        msg_len = p + 1;
      end
    end
    // A message over the length limit is thrown away.
    if (msg_len > int'(max_len_reg)) begin
      clear_message();
      ff_count = '0;
      st = smdp_pkg::ST_OVERFLOW;
      sid = 0;
      val = 0;
    end
    r.status = st;
    r.sid = sid[2:0];
    r.value = val[16:0];
    r.co2 = level_store[smdp_pkg::SID_CO2][13:0];
    r.pm25 = level_store[smdp_pkg::SID_PM25][10:0];
    r.ozone = level_store[smdp_pkg::SID_O3][10:0];
    r.temp = level_store[smdp_pkg::SID_TEMP][7:0];
    r.hum = level_store[smdp_pkg::SID_HUM][6:0];
    r.voc = level_store[smdp_pkg::SID_TVOC][10:0];
    return r;
  endfunction

  // Send one byte request, with a random gap first, and record its report.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (full_seen) @(posedge clk);
    pending_reports.push_back(deframe_byte(b));
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_term(input int n);
    repeat (n) send_byte(smdp_pkg::BYTE_TERM);
  endtask

  // Send a message followed by a full terminator run.
  task automatic send_message(input string s);
    send_text(s);
    send_term((term_run_reg == 0) ? 1 : int'(term_run_reg));
  endtask

  // Stop sending and let every outstanding result come back.
  task automatic settle();
    push <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write while the block is idle.
  task automatic write_reg(input logic [smdp_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [7:0] data);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == smdp_pkg::REG_MAX_MESSAGE_LENGTH) max_len_reg = data;
    else term_run_reg = data[2:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One random frame: mostly well-formed, the rest noise or cut short.
  task automatic send_random_frame();
    int pick;
    int sid;
    int v;
    int run;
    string body;
    pick = int'($urandom_range(99));
    sid = int'($urandom_range(smdp_pkg::NUM_SENSORS - 1));
    if (pick < 75) begin
      body = sensor_key[sid];
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) body = {body, " "};
      case ($urandom_range(3))
        0: v = range_min[sid] + int'($urandom_range(range_max[sid] - range_min[sid]));
        1: v = (($urandom_range(1) == 0) ? range_min[sid] : range_max[sid]) +
               int'($urandom_range(2)) - 1;
        2: v = int'($urandom_range(140000)) - 70000;
        default: v = int'($urandom_range(20)) - 10;
      endcase
      if (v < 0) body = {body, "-"};
      else if ($urandom_range(3) == 0) body = {body, "+"};
      if ($urandom_range(7) == 0) body = {body, "0"};
      body = {body, $sformatf("%0d", (v < 0) ? -v : v)};
      send_text(body);
      if ($urandom_range(3) == 0) send_byte(8'($urandom_range(32, 126)));
      if ($urandom_range(5) == 0) send_byte(8'($urandom_range(0, 31)));
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(255)));
    end else if (pick < 93) begin
      send_text(sensor_key[sid].substr(0, int'($urandom_range(sensor_key[sid].len() - 2))));
    end else begin
      repeat ($urandom_range(1, 20)) send_byte(8'($urandom_range(32, 126)));
    end
    run = (term_run_reg == 0) ? 1 : int'(term_run_reg);
    if ($urandom_range(9) == 0) run = int'($urandom_range(0, 8));
    send_term(run);
  endtask

  task automatic random_frames(input int count);
    int stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) send_random_frame();
  endtask

  // Terminator runs with nothing in the message report nothing.
  task automatic test_empty_frames();
    send_term(3);
    send_byte(8'h00);
    send_term(3);
  endtask

  // One good message per sensor, edges of the ranges among them.
  task automatic test_each_sensor();
    send_message("co2V.val=9999");
    send_message("pm25V.val=  1999");
    send_message("o3V.val=+0");
    send_message("tempV.val=-50");
    send_message("humV.val=100");
    send_message("tvocV.val=1234");
  endtask

  task automatic test_out_of_range();
    send_message("co2V.val=0");
    send_message("tempV.val=100");
    send_message("humV.val=-1");
  endtask

  // Unknown names and messages that end inside a key.
  task automatic test_unknown_keys();
    send_message("co2V");
    send_message("xyz");
    send_message("~");
  endtask

  // Spaces, signs, trailing text and missing digits.
  task automatic test_number_syntax();
    send_message("tempV.val= +12abc");
    send_message("o3V.val=");
    send_message("pm25V.val=- 5");
    send_message("humV.val=007 9");
  endtask

  task automatic test_saturation();
    send_message("pm25V.val=1234567");
    send_message("tempV.val=-99999");
  endtask

  // Control bytes are dropped and a short 0xFF run does not end the message.
  task automatic test_dropped_bytes();
    send_text("co2V.val=4");
    send_byte(8'h00);
    send_byte(8'h0A);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_text("2");
    send_term(2);
    send_text("1");
    send_term(3);
  endtask

  // A message one byte over a lowered limit.
  task automatic test_overflow();
    write_reg(smdp_pkg::REG_MAX_MESSAGE_LENGTH, 8'd20);
    repeat (21) send_byte("a");
    send_message("co2V.val=5");
    write_reg(smdp_pkg::REG_MAX_MESSAGE_LENGTH, 8'd100);
  endtask

  // Limit lowered while a message is half received.
  task automatic test_late_lowering();
    send_text("hum");
    write_reg(smdp_pkg::REG_MAX_MESSAGE_LENGTH, 8'd2);
    send_byte(8'h01);
    write_reg(smdp_pkg::REG_MAX_MESSAGE_LENGTH, 8'd100);
    send_text("co2V.val=7");
    send_term(2);
    write_reg(smdp_pkg::REG_MAX_MESSAGE_LENGTH, 8'd2);
    // The terminating byte wins over the lowered limit.
    send_byte(smdp_pkg::BYTE_TERM);
    write_reg(smdp_pkg::REG_MAX_MESSAGE_LENGTH, 8'd100);
  endtask

  // Each register set to zero in turn.
  task automatic test_register_zero();
    write_reg(smdp_pkg::REG_MAX_MESSAGE_LENGTH, 8'd0);
    send_byte("c");
    send_byte(smdp_pkg::BYTE_TERM);
    write_reg(smdp_pkg::REG_MAX_MESSAGE_LENGTH, 8'd100);
    write_reg(smdp_pkg::REG_TERMINATOR_RUN, 8'd0);
    send_byte(smdp_pkg::BYTE_TERM);
    send_message("co2V.val=8");
    write_reg(smdp_pkg::REG_TERMINATOR_RUN, 8'd3);
  endtask

  // Largest register settings, then both registers at one.
  task automatic test_register_extremes();
    write_reg(smdp_pkg::REG_MAX_MESSAGE_LENGTH, 8'hFF);
    write_reg(smdp_pkg::REG_TERMINATOR_RUN, 8'hFF);
    send_text("tvocV.val=12");
    repeat (3) send_byte("z");
    send_term(7);
    send_text("humV.val=55");
    repeat (4) send_byte("z");
    send_term(7);
    write_reg(smdp_pkg::REG_MAX_MESSAGE_LENGTH, 8'd1);
    write_reg(smdp_pkg::REG_TERMINATOR_RUN, 8'd1);
    send_byte("a");
    send_byte(smdp_pkg::BYTE_TERM);
    send_text("ab");
    send_term(2);
    // Upper data bits are ignored by the terminator register.
    write_reg(smdp_pkg::REG_TERMINATOR_RUN, 8'hFB);
    write_reg(smdp_pkg::REG_MAX_MESSAGE_LENGTH, 8'd100);
  endtask

  // Random traffic over several register settings.
  task automatic test_random_traffic();
    random_frames(8);
    settle();
    idle_pct = 0;
    random_frames(25);
    idle_pct = 36;
    write_reg(smdp_pkg::REG_MAX_MESSAGE_LENGTH, 8'd255);
    write_reg(smdp_pkg::REG_TERMINATOR_RUN, 8'd7);
    random_frames(8);
    write_reg(smdp_pkg::REG_MAX_MESSAGE_LENGTH, 8'd12);
    write_reg(smdp_pkg::REG_TERMINATOR_RUN, 8'd1);
    random_frames(8);
    repeat (2) begin
      write_reg(smdp_pkg::REG_MAX_MESSAGE_LENGTH,
                ($urandom_range(1) == 0) ? 8'($urandom_range(8, 30))
                                         : 8'($urandom_range(1, 255)));
      write_reg(smdp_pkg::REG_TERMINATOR_RUN, 8'($urandom_range(1, 7)));
      random_frames(5);
    end
  endtask

  // Run limit.
  initial begin
    #4000000;
    $display("testbench failed");
    $finish;
  end

  // Reset, then the tests in turn, then the verdict.
  initial begin
    rst = 1'b1;
    push = 1'b0;
    rx_byte = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    max_len_reg = smdp_pkg::MAX_LEN_RESET;
    term_run_reg = smdp_pkg::TERM_RUN_RESET;
    ff_count = '0;
    clear_message();
    foreach (level_store[k]) level_store[k] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_frames();
    test_each_sensor();
    test_out_of_range();
    test_unknown_keys();
    test_number_syntax();
    test_saturation();
    test_dropped_bytes();
    test_overflow();
    test_late_lowering();
    test_register_zero();
    test_register_extremes();
    test_random_traffic();

    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
